FILE: design/superfast_hash_32_unit_defines.svh
// Assertion macros for the superfast_hash_32_unit design.
// Each macro expands to one labeled concurrent assertion on clk, gated by rst_n.
`ifndef SUPERFAST_HASH_32_UNIT_DEFINES_SVH
`define SUPERFAST_HASH_32_UNIT_DEFINES_SVH

// same-cycle implication
`define SHF_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SHF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/shf_pkg.sv
// Shared types, constants and mixing functions of the SuperFastHash unit.
// No dependencies; the unit, front end, queue and finalizer import this package.
package shf_pkg;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam logic [1:0] PHASE_NONE  = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;
    localparam logic [1:0] PHASE_THREE = 2'd3;

    // one finished message waiting for finalization
    typedef struct packed {
        logic [31:0] hash;
        logic [1:0]  phase;
        logic [23:0] pend;
        logic        zero;
    } job_t;

    function automatic logic [31:0] sext8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    function automatic logic [31:0] word_round(input logic [31:0] h_in,
                                               input logic [15:0] lo16,
                                               input logic [15:0] hi16);
        logic [31:0] h;
        logic [31:0] t;
        h = h_in + {16'd0, lo16};
        t = {5'd0, hi16, 11'd0} ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic logic [31:0] tail_mix(input logic [31:0] h_in,
                                             input logic [1:0]  phase,
                                             input logic [23:0] pend);
        logic [31:0] h;
        h = h_in;
        case (phase)
            PHASE_THREE:
            begin
                h = h + {16'd0, pend[15:0]};
                h = h ^ (h << 16);
                h = h ^ (sext8(pend[23:16]) << 18);
                h = h + (h >> 11);
            end
            PHASE_TWO:
            begin
                h = h + {16'd0, pend[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            PHASE_ONE:
            begin
                h = h + sext8(pend[7:0]);
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default:
            begin
                h = h_in;
            end
        endcase
        return h;
    endfunction

    // avalanche, split in three pairs of steps
    function automatic logic [31:0] aval_a(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in ^ (h_in << 3);
        h = h + (h >> 5);
        return h;
    endfunction

    function automatic logic [31:0] aval_b(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in ^ (h_in << 4);
        h = h + (h >> 17);
        return h;
    endfunction

    function automatic logic [31:0] aval_c(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in ^ (h_in << 25);
        h = h + (h >> 6);
        return h;
    endfunction

endpackage

FILE: design/shf_byte_if.sv
// Byte input channel of the SuperFastHash unit: valid/ready plus one message byte.
// No dependencies.
interface shf_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [30:0] message_length;

    modport source (output valid, input ready,
                    output data_byte, output first_byte, output last_byte,
                    output message_length);
    modport sink   (input valid, output ready,
                    input data_byte, input first_byte, input last_byte,
                    input message_length);
endinterface

FILE: design/shf_hash_if.sv
// Hash result channel of the SuperFastHash unit: valid/ready plus the 32-bit hash.
// No dependencies.
interface shf_hash_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, input ready, output hash_value);
    modport sink   (input valid, output ready, input hash_value);
endinterface

FILE: design/superfast_hash_32_unit.sv
// SuperFastHash (32-bit) over a byte stream. Takes one byte beat per cycle while the queue
// has room: the front end keeps the running hash and runs a word round in the cycle that
// completes each 4-byte word; the round is combinational, so it does not slow the byte
// rate. A beat marked last (or a first beat with length zero) hands the message to a
// 4-entry queue; the finalizer runs it through s1 (tail mix), then s2, s3 and the output
// register (avalanche). A stalled result side backs up the pipe, then the queue;
// byte_ch.ready drops only when the queue is full. No clearing pass after reset.
`include "superfast_hash_32_unit_defines.svh"

module superfast_hash_32_unit (
    input  logic       clk,
    input  logic       rst_n,
    shf_byte_if.sink   byte_ch,
    shf_hash_if.source hash_ch
);
    import shf_pkg::*;

    logic push;
    job_t push_job;
    logic job_pop;
    job_t head_job;
    logic job_valid;
    logic q_full;

    shf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    shf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (job_pop),
        .head_job  (head_job),
        .not_empty (job_valid),
        .full      (q_full)
    );

    shf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (head_job),
        .job_pop   (job_pop),
        .hash_ch   (hash_ch)
    );

    `SHF_ASSERT_NEXT(a_result_queued, push, job_valid, "finished message not in queue")
    `SHF_ASSERT_IMPL(a_pop_nonempty, job_pop, job_valid, "finalizer popped an empty queue")
    `SHF_ASSERT_IMPL(a_push_room, push, !q_full, "message pushed into a full queue")

endmodule

FILE: design/shf_front.sv
// Front end: takes byte beats, packs words, runs the word round, queues finished messages.
// Depends on shf_pkg and shf_byte_if.
module shf_front (
    input  logic          clk,
    input  logic          rst_n,
    shf_byte_if.sink      byte_ch,
    input  logic          q_full,
    output logic          push,
    output shf_pkg::job_t push_job
);
    import shf_pkg::*;

    logic [31:0] hash_reg, hash_next;
    logic [1:0]  phase_reg, phase_next;
    logic [23:0] pend_reg, pend_next;

    logic        accept;
    logic        zero_len;
    logic [31:0] base_hash;
    logic [1:0]  base_phase;
    logic [23:0] base_pend;
    logic [31:0] word;
    logic [31:0] step_hash;
    logic [1:0]  step_phase;
    logic [23:0] step_pend;

    assign byte_ch.ready = !q_full;
    assign accept        = byte_ch.valid && byte_ch.ready;
    assign zero_len      = byte_ch.first_byte && (byte_ch.message_length == 31'd0);

    always_comb
    begin
        base_hash  = byte_ch.first_byte ? {1'b0, byte_ch.message_length} : hash_reg;
        base_phase = byte_ch.first_byte ? PHASE_NONE : phase_reg;
        base_pend  = byte_ch.first_byte ? 24'd0 : pend_reg;
        word       = {byte_ch.data_byte, base_pend};
        if (base_phase == PHASE_THREE)
        begin
            step_hash  = word_round(base_hash, word[15:0], word[31:16]);
            step_phase = PHASE_NONE;
            step_pend  = 24'd0;
        end
        else
        begin
            step_hash  = base_hash;
            step_phase = base_phase + 2'd1;
            step_pend  = base_pend | ({16'd0, byte_ch.data_byte} << {base_phase, 3'b000});
        end
    end

    always_comb
    begin
        hash_next  = hash_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        if (accept)
        begin
            if (zero_len || byte_ch.last_byte)
            begin
                hash_next  = 32'd0;
                phase_next = PHASE_NONE;
                pend_next  = 24'd0;
            end
            else
            begin
                hash_next  = step_hash;
                phase_next = step_phase;
                pend_next  = step_pend;
            end
        end
    end

    assign push           = accept && (zero_len || byte_ch.last_byte);
    assign push_job.hash  = step_hash;
    assign push_job.phase = step_phase;
    assign push_job.pend  = step_pend;
    assign push_job.zero  = zero_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= 32'd0;
            phase_reg <= PHASE_NONE;
            pend_reg  <= 24'd0;
        end
        else
        begin
            hash_reg  <= hash_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

FILE: design/shf_queue.sv
// Short FIFO of finished messages between the front end and the finalizer.
// Depends on shf_pkg.
module shf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  shf_pkg::job_t push_job,
    input  logic          pop,
    output shf_pkg::job_t head_job,
    output logic          not_empty,
    output logic          full
);
    import shf_pkg::*;

    job_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign head_job  = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/shf_back.sv
// Finalizer: tail mix and six-step avalanche in four stages, last stage is the output register.
// Depends on shf_pkg and shf_hash_if.
module shf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  shf_pkg::job_t job,
    output logic          job_pop,
    shf_hash_if.source    hash_ch
);
    import shf_pkg::*;

    logic        adv;
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic [31:0] s1_hash_reg, s2_hash_reg, s3_hash_reg, out_hash_reg;
    logic        s1_zero_reg, s2_zero_reg, s3_zero_reg;
    logic [31:0] out_hash_next;

    // whole pipe moves unless a result sits unaccepted at the output
    assign adv     = !out_valid_reg || hash_ch.ready;
    assign job_pop = adv && job_valid;

    assign out_hash_next = s3_zero_reg ? 32'd0 : aval_c(s3_hash_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_hash_reg  <= tail_mix(job.hash, job.phase, job.pend);
            s1_zero_reg  <= job.zero;
            s2_hash_reg  <= aval_a(s1_hash_reg);
            s2_zero_reg  <= s1_zero_reg;
            s3_hash_reg  <= aval_b(s2_hash_reg);
            s3_zero_reg  <= s2_zero_reg;
            out_hash_reg <= out_hash_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= job_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    assign hash_ch.valid      = out_valid_reg;
    assign hash_ch.hash_value = out_hash_reg;

endmodule
